@@ sv/gbsp_pkg.sv @@
// Shared types and constants for the GIF block stream parser.
// Parse states, block kinds, marker bytes and the colour table size function.
// No dependencies.
package gbsp_pkg;

   typedef enum logic [3:0] {
      ST_HDR    = 4'd0,
      ST_SCR    = 4'd1,
      ST_GTAB   = 4'd2,
      ST_INTRO  = 4'd3,
      ST_LABEL  = 4'd4,
      ST_GFX    = 4'd5,
      ST_APPH   = 4'd6,
      ST_APPSZ  = 4'd7,
      ST_APPSUB = 4'd8,
      ST_IMGD   = 4'd9,
      ST_LTAB   = 4'd10,
      ST_LZW    = 4'd11,
      ST_IMGSZ  = 4'd12,
      ST_IMGSUB = 4'd13,
      ST_DONE   = 4'd14,
      ST_ERR    = 4'd15
   } parse_state_type;

   typedef enum logic [3:0] {
      K_HEADER   = 4'd0,
      K_SCREEN   = 4'd1,
      K_GTABLE   = 4'd2,
      K_EXTINTRO = 4'd3,
      K_GFXCTRL  = 4'd4,
      K_APPHDR   = 4'd5,
      K_APPSUB   = 4'd6,
      K_IMGDESC  = 4'd7,
      K_LTABLE   = 4'd8,
      K_LZWSIZE  = 4'd9,
      K_IMGSUB   = 4'd10,
      K_TERM     = 4'd11,
      K_TRAILER  = 4'd12,
      K_INVALID  = 4'd13
   } block_kind_type;

   localparam int unsigned COUNT_W = 10;

   localparam logic [7:0] BYTE_EXT     = 8'h21;
   localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
   localparam logic [7:0] BYTE_TRAILER = 8'h3B;
   localparam logic [7:0] LABEL_GFX    = 8'hF9;
   localparam logic [7:0] LABEL_APP    = 8'hFF;

   localparam logic [COUNT_W-1:0] LEN_HEADER = 10'd6;
   localparam logic [COUNT_W-1:0] LEN_SCREEN = 10'd7;
   localparam logic [COUNT_W-1:0] LEN_IMGD   = 10'd10;
   localparam logic [COUNT_W-1:0] LEN_GFX    = 10'd8;
   localparam logic [COUNT_W-1:0] LEN_APPH   = 10'd14;
   localparam logic [COUNT_W-1:0] POS_SCR_PACKED  = 10'd4;
   localparam logic [COUNT_W-1:0] POS_IMGD_PACKED = 10'd9;

   typedef struct packed {
      block_kind_type kind;
      logic           first;
      logic           last;
      logic           error;
      logic           done;
   } tag_type;

   // Colour table bytes: 3 * 2^(n+1) when the table flag is set, else none.
   function automatic logic [COUNT_W-1:0] table_bytes(input logic [7:0] packed_byte);
      logic [3:0] shift;
      shift = {1'b0, packed_byte[2:0]} + 4'd1;
      if (packed_byte[7]) begin
         return 10'd3 << shift;
      end
      return '0;
   endfunction

endpackage

@@ sv/gbsp_fsm.sv @@
// Block tracking state machine: tags one byte per advance and updates parse state.
// Depends on gbsp_pkg.
module gbsp_fsm
   import gbsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] data_byte,
   output tag_type    tag
);

   parse_state_type    state_ff, state_in;
   logic [COUNT_W-1:0] bib_ff, bib_in;
   logic [COUNT_W-1:0] len_ff, len_in;
   logic [COUNT_W-1:0] tf_ff, tf_in;
   logic               err_ff, err_in;
   logic               done_ff, done_in;

   logic [COUNT_W:0]   bib_next;
   logic               count_last;
   logic [COUNT_W-1:0] sub_len;

   assign bib_next   = {1'b0, bib_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign count_last = bib_next >= {1'b0, len_ff};
   assign sub_len    = {2'b00, data_byte} + 10'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HDR;
         bib_ff   <= '0;
         len_ff   <= LEN_HEADER;
         tf_ff    <= '0;
         err_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
         bib_ff   <= bib_in;
         len_ff   <= len_in;
         tf_ff    <= tf_in;
         err_ff   <= err_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      bib_in    = bib_ff;
      len_in    = len_ff;
      tf_in     = tf_ff;
      err_in    = err_ff;
      done_in   = done_ff;
      tag.kind  = K_INVALID;
      tag.first = 1'b0;
      tag.last  = 1'b0;
      unique case (state_ff)
         ST_HDR, ST_SCR, ST_GTAB, ST_GFX, ST_APPH, ST_APPSUB, ST_IMGD, ST_LTAB,
         ST_IMGSUB: begin
            case (state_ff)
               ST_HDR:    tag.kind = K_HEADER;
               ST_SCR:    tag.kind = K_SCREEN;
               ST_GTAB:   tag.kind = K_GTABLE;
               ST_GFX:    tag.kind = K_GFXCTRL;
               ST_APPH:   tag.kind = K_APPHDR;
               ST_APPSUB: tag.kind = K_APPSUB;
               ST_IMGD:   tag.kind = K_IMGDESC;
               ST_LTAB:   tag.kind = K_LTABLE;
               default:   tag.kind = K_IMGSUB;
            endcase
            tag.first = (bib_ff == '0);
            tag.last  = count_last;
            // The packed byte sets the size of the table that follows.
            if ((state_ff == ST_SCR && bib_ff == POS_SCR_PACKED) ||
                (state_ff == ST_IMGD && bib_ff == POS_IMGD_PACKED)) begin
               tf_in = table_bytes(data_byte);
            end
            if (!count_last) begin
               bib_in = bib_next[COUNT_W-1:0];
            end else begin
               bib_in = '0;
               len_in = '0;
               case (state_ff)
                  ST_HDR: begin
                     state_in = ST_SCR;
                     len_in   = LEN_SCREEN;
                  end
                  ST_SCR: begin
                     if (tf_in != '0) begin
                        state_in = ST_GTAB;
                        len_in   = tf_in;
                     end else begin
                        state_in = ST_INTRO;
                     end
                  end
                  ST_IMGD: begin
                     if (tf_in != '0) begin
                        state_in = ST_LTAB;
                        len_in   = tf_in;
                     end else begin
                        state_in = ST_LZW;
                     end
                  end
                  ST_LTAB:            state_in = ST_LZW;
                  ST_APPH, ST_APPSUB: state_in = ST_APPSZ;
                  ST_IMGSUB:          state_in = ST_IMGSZ;
                  default:            state_in = ST_INTRO;
               endcase
            end
         end
         ST_INTRO: begin
            tag.first = 1'b1;
            len_in    = '0;
            bib_in    = '0;
            if (data_byte == BYTE_EXT) begin
               tag.kind = K_EXTINTRO;
               state_in = ST_LABEL;
               bib_in   = 10'd1;
            end else if (data_byte == BYTE_IMAGE) begin
               tag.kind = K_IMGDESC;
               state_in = ST_IMGD;
               bib_in   = 10'd1;
               len_in   = LEN_IMGD;
            end else if (data_byte == BYTE_TRAILER) begin
               tag.kind = K_TRAILER;
               tag.last = 1'b1;
               done_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               tag.last = 1'b1;
               err_in   = 1'b1;
               state_in = ST_ERR;
            end
         end
         ST_LABEL: begin
            // Count from the introducer: the label is the second byte position.
            if (data_byte == LABEL_GFX) begin
               tag.kind = K_GFXCTRL;
               state_in = ST_GFX;
               bib_in   = 10'd2;
               len_in   = LEN_GFX;
            end else if (data_byte == LABEL_APP) begin
               tag.kind = K_APPHDR;
               state_in = ST_APPH;
               bib_in   = 10'd2;
               len_in   = LEN_APPH;
            end else begin
               tag.first = 1'b1;
               tag.last  = 1'b1;
               err_in    = 1'b1;
               state_in  = ST_ERR;
               bib_in    = '0;
               len_in    = '0;
            end
         end
         ST_LZW: begin
            tag.kind  = K_LZWSIZE;
            tag.first = 1'b1;
            tag.last  = 1'b1;
            state_in  = ST_IMGSZ;
            bib_in    = '0;
            len_in    = '0;
         end
         ST_APPSZ, ST_IMGSZ: begin
            tag.first = 1'b1;
            if (data_byte == 8'd0) begin
               tag.kind = K_TERM;
               tag.last = 1'b1;
               state_in = ST_INTRO;
               bib_in   = '0;
               len_in   = '0;
            end else begin
               tag.kind = (state_ff == ST_APPSZ) ? K_APPSUB : K_IMGSUB;
               state_in = (state_ff == ST_APPSZ) ? ST_APPSUB : ST_IMGSUB;
               bib_in   = 10'd1;
               len_in   = sub_len;
            end
         end
         ST_DONE, ST_ERR: begin
            // Drop everything after the trailer or an error.
         end
      endcase
      tag.error = err_in;
      tag.done  = done_in;
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("parse error flag cleared");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_DONE && done_ff)
      else $error("left done state after trailer");

   a_err_state: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ERR |-> err_ff && !done_ff)
      else $error("error state without error flag");

endmodule

@@ sv/gif_block_stream_parser.sv @@
// GIF block stream parser: takes one GIF byte per transfer and returns one tagged byte per
// transfer. Throughput is one byte per clock while rsp_stall is low; a request passes the
// input register, then the response register. The rate is set by the parse state update in
// gbsp_fsm, which classifies the byte held in the input register and writes the response
// register in the same cycle. The input register lets one request be taken while a finished
// response is held stalled. Every byte gives exactly one response; after the trailer or an
// unknown introducer or label, bytes come back tagged invalid. Depends on gbsp_pkg, gbsp_fsm.
module gif_block_stream_parser
   import gbsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_block_kind,
   output logic       rsp_block_first,
   output logic       rsp_block_last,
   output logic       rsp_parse_error,
   output logic       rsp_stream_done
);

   // Input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   // Response stage
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   tag_type    out_tag_ff;

   logic       s1_adv;
   logic       req_take;
   tag_type    tag;

   // Advance the input stage whenever the response register is free or draining.
   assign s1_adv   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take = req_valid && !req_stall;

   gbsp_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_adv),
      .data_byte (s1_byte_ff),
      .tag       (tag)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: hold while stalled, load on transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_in_byte;
      end
      if (s1_adv) begin
         out_byte_ff <= s1_byte_ff;
         out_tag_ff  <= tag;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_block_kind  = out_tag_ff.kind;
   assign rsp_block_first = out_tag_ff.first;
   assign rsp_block_last  = out_tag_ff.last;
   assign rsp_parse_error = out_tag_ff.error;
   assign rsp_stream_done = out_tag_ff.done;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled with room in the pipeline");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("input stage lost a held byte");

endmodule

@@ test/tb_gif_block_stream_parser.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gif_block_stream_parser: one long random GIF89a stream,
// predicted byte by byte and compared with the tagged responses. Depends on gbsp_pkg, gif_block_stream_parser.
module tb_gif_block_stream_parser;
   import gbsp_pkg::*;

   // Expected tag of one byte, laid out like the response ports.
   typedef struct {
      logic [7:0]     data;
      block_kind_type kind;
      logic           first;
      logic           last;
      logic           err;
      logic           done;
   } byte_tag_type;

   // One byte waiting to be sent; the flag holds it back until the parser has drained.
   typedef struct {
      logic [7:0] data;
      logic       hold_for_drain;
   } stream_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [3:0] rsp_block_kind;
   logic       rsp_block_first;
   logic       rsp_block_last;
   logic       rsp_parse_error;
   logic       rsp_stream_done;

   gif_block_stream_parser u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_block_kind  (rsp_block_kind),
      .rsp_block_first (rsp_block_first),
      .rsp_block_last  (rsp_block_last),
      .rsp_parse_error (rsp_parse_error),
      .rsp_stream_done (rsp_stream_done)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Bytes still to send and tags still to arrive.
   stream_byte_type gif_stream[$];
   byte_tag_type    expected_tags[$];

   // Parser shadow state.
   parse_state_type     shadow_state;
   logic [COUNT_W-1:0]  shadow_pos;
   logic [COUNT_W-1:0]  shadow_len;
   logic [COUNT_W-1:0]  shadow_table;
   logic                shadow_err;
   logic                shadow_done;

   // Bookkeeping shared between the driver, the monitor and the end-of-test sequence.
   int     pending_results = 0;   // updated with NBAs so the driver reads a stable value
   logic   tail_phase = 1'b0;     // no idling on either side once set
   int     error_count = 0;
   int     checked_count = 0;
   int     cycle_count = 0;
   int     cycle_limit = 1000000;
   int     gap_left = 0;
   int     stall_left = 0;
   int     rsp_cycle = 0;
   logic   drain_request = 1'b0;
   int     image_count = 0;
   int     extension_count = 0;
   int     largest_table = 0;
   string  ending;
   logic          accepted;
   logic          returned;
   byte_tag_type  tag_now;
   byte_tag_type  tag_want;

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Color table size that a packed descriptor byte announces.
   function automatic logic [COUNT_W-1:0] color_table_size(input logic [7:0] packed_byte);
      if (!packed_byte[7]) begin
         return '0;
      end
      return COUNT_W'(3 << (int'(packed_byte[2:0]) + 1));
   endfunction

   function automatic void enter_block(input parse_state_type st,
                                       input logic [COUNT_W-1:0] pos,
                                       input logic [COUNT_W-1:0] len);
      shadow_state = st;
      shadow_pos   = pos;
      shadow_len   = len;
   endfunction

   // Tag one byte and advance the shadow state.
   function automatic byte_tag_type tag_gif_byte(input logic [7:0] b);
      byte_tag_type t;
      logic [COUNT_W:0] next_pos;
      t.data  = b;
      t.kind  = K_INVALID;
      t.first = 1'b0;
      t.last  = 1'b0;
      case (shadow_state)
         ST_HDR, ST_SCR, ST_GTAB, ST_GFX, ST_APPH, ST_APPSUB, ST_IMGD, ST_LTAB,
         ST_IMGSUB: begin
            case (shadow_state)
               ST_HDR:    t.kind = K_HEADER;
               ST_SCR:    t.kind = K_SCREEN;
               ST_GTAB:   t.kind = K_GTABLE;
               ST_GFX:    t.kind = K_GFXCTRL;
               ST_APPH:   t.kind = K_APPHDR;
               ST_APPSUB: t.kind = K_APPSUB;
               ST_IMGD:   t.kind = K_IMGDESC;
               ST_LTAB:   t.kind = K_LTABLE;
               default:   t.kind = K_IMGSUB;
            endcase
            t.first  = (shadow_pos == '0);
            next_pos = {1'b0, shadow_pos} + 1'b1;
            t.last   = (next_pos >= {1'b0, shadow_len});
            // the packed byte of either descriptor decides the table that follows
            if ((shadow_state == ST_SCR && shadow_pos == POS_SCR_PACKED) ||
                (shadow_state == ST_IMGD && shadow_pos == POS_IMGD_PACKED)) begin
               shadow_table = color_table_size(b);
            end
            if (!t.last) begin
               shadow_pos = shadow_pos + 1'b1;
            end else begin
               case (shadow_state)
                  ST_HDR: enter_block(ST_SCR, '0, LEN_SCREEN);
                  ST_SCR: begin
                     if (shadow_table != '0) enter_block(ST_GTAB, '0, shadow_table);
                     else enter_block(ST_INTRO, '0, '0);
                  end
                  ST_IMGD: begin
                     if (shadow_table != '0) enter_block(ST_LTAB, '0, shadow_table);
                     else enter_block(ST_LZW, '0, '0);
                  end
                  ST_LTAB:            enter_block(ST_LZW, '0, '0);
                  ST_APPH, ST_APPSUB: enter_block(ST_APPSZ, '0, '0);
                  ST_IMGSUB:          enter_block(ST_IMGSZ, '0, '0);
                  default:            enter_block(ST_INTRO, '0, '0);
               endcase
            end
         end
         ST_INTRO: begin
            t.first = 1'b1;
            if (b == BYTE_EXT) begin
               t.kind = K_EXTINTRO;
               enter_block(ST_LABEL, COUNT_W'(1), '0);
            end else if (b == BYTE_IMAGE) begin
               t.kind = K_IMGDESC;
               enter_block(ST_IMGD, COUNT_W'(1), LEN_IMGD);
            end else if (b == BYTE_TRAILER) begin
               t.kind = K_TRAILER;
               t.last = 1'b1;
               shadow_done = 1'b1;
               enter_block(ST_DONE, '0, '0);
            end else begin
               t.last = 1'b1;
               shadow_err = 1'b1;
               enter_block(ST_ERR, '0, '0);
            end
         end
         ST_LABEL: begin
            // the label continues the block opened by the introducer
            if (b == LABEL_GFX) begin
               t.kind = K_GFXCTRL;
               enter_block(ST_GFX, COUNT_W'(2), LEN_GFX);
            end else if (b == LABEL_APP) begin
               t.kind = K_APPHDR;
               enter_block(ST_APPH, COUNT_W'(2), LEN_APPH);
            end else begin
               t.first = 1'b1;
               t.last  = 1'b1;
               shadow_err = 1'b1;
               enter_block(ST_ERR, '0, '0);
            end
         end
         ST_LZW: begin
            t.kind  = K_LZWSIZE;
            t.first = 1'b1;
            t.last  = 1'b1;
            enter_block(ST_IMGSZ, '0, '0);
         end
         ST_APPSZ, ST_IMGSZ: begin
            t.first = 1'b1;
            if (b == 8'h00) begin
               t.kind = K_TERM;
               t.last = 1'b1;
               enter_block(ST_INTRO, '0, '0);
            end else if (shadow_state == ST_APPSZ) begin
               t.kind = K_APPSUB;
               enter_block(ST_APPSUB, COUNT_W'(1), {2'b00, b} + 1'b1);
            end else begin
               t.kind = K_IMGSUB;
               enter_block(ST_IMGSUB, COUNT_W'(1), {2'b00, b} + 1'b1);
            end
         end
         default: begin
            // done or error: the byte is only passed through
         end
      endcase
      t.err  = shadow_err;
      t.done = shadow_done;
      return t;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stream builder
   // ---------------------------------------------------------------------------------------

   task automatic put(input logic [7:0] b);
      stream_byte_type item;
      item.data = b;
      item.hold_for_drain = drain_request;
      drain_request = 1'b0;
      gif_stream.push_back(item);
   endtask

   // Zero-ended chain of data sub-blocks; mostly short, now and then a full 255-byte one.
   task automatic put_sub_chain();
      int blocks;
      int size;
      blocks = $urandom_range(0, 3);
      repeat (blocks) begin
         size = ($urandom_range(0, 11) == 0) ? 255 : $urandom_range(1, 8);
         put(8'(size));
         repeat (size) put(8'($urandom));
      end
      put(8'h00);
   endtask

   task automatic put_gfx_ext();
      put(BYTE_EXT);
      put(LABEL_GFX);
      repeat (6) put(8'($urandom));
      extension_count++;
   endtask

   task automatic put_image(input logic [7:0] packed_byte);
      int tbl;
      put(BYTE_IMAGE);
      repeat (8) put(8'($urandom));
      put(packed_byte);
      tbl = color_table_size(packed_byte);
      if (tbl > largest_table) largest_table = tbl;
      repeat (tbl) put(8'($urandom));
      put(8'($urandom));   // LZW minimum code size
      put_sub_chain();
      image_count++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: present the next byte whenever the current one has been taken or none is up.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'h00;
         gap_left = 0;
      end else begin
         tail_phase <= (gif_stream.size() <= 200);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (gif_stream.size() == 0) begin
               req_valid <= 1'b0;
            end else if (gif_stream[0].hold_for_drain && (req_valid || pending_results != 0)) begin
               // hold off until every outstanding tag is back
               req_valid <= 1'b0;
            end else begin
               req_valid   <= 1'b1;
               req_in_byte <= gif_stream[0].data;
               gif_stream.pop_front();
               // idle in bursts, but leave calm stretches and a quiet tail
               if (gif_stream.size() > 200 && (gif_stream.size() % 300) >= 80 &&
                   $urandom_range(0, 9) == 0) begin
                  gap_left = $urandom_range(1, 11);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Response side: random stall bursts.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         rsp_cycle  = 0;
      end else begin
         rsp_cycle++;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!tail_phase && (rsp_cycle % 700) >= 150 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: predict every accepted byte, then check every returned tag in order.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         shadow_state = ST_HDR;
         shadow_pos   = '0;
         shadow_len   = LEN_HEADER;
         shadow_table = '0;
         shadow_err   = 1'b0;
         shadow_done  = 1'b0;
         pending_results <= 0;
      end else begin
         accepted = req_valid && !req_stall;
         returned = rsp_valid && !rsp_stall;
         // push before pop so the oldest expectation is always at the front
         if (accepted) begin
            tag_now = tag_gif_byte(req_in_byte);
            expected_tags.push_back(tag_now);
         end
         if (returned) begin
            checked_count++;
            if (expected_tags.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("[%0t] unexpected transfer: byte %02h kind %0d", $realtime,
                           rsp_out_byte, rsp_block_kind);
            end else begin
               tag_want = expected_tags.pop_front();
               if (rsp_out_byte !== tag_want.data || rsp_block_kind !== tag_want.kind ||
                   rsp_block_first !== tag_want.first || rsp_block_last !== tag_want.last ||
                   rsp_parse_error !== tag_want.err || rsp_stream_done !== tag_want.done) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("[%0t] mismatch: exp byte %02h kind %0d f%0b l%0b e%0b d%0b, got byte %02h kind %0d f%0b l%0b e%0b d%0b",
                              $realtime, tag_want.data, tag_want.kind, tag_want.first,
                              tag_want.last, tag_want.err, tag_want.done, rsp_out_byte,
                              rsp_block_kind, rsp_block_first, rsp_block_last,
                              rsp_parse_error, rsp_stream_done);
               end
            end
         end
         pending_results <= pending_results + int'(accepted) - int'(returned);
      end
   end

   // Watchdog: a hung handshake or a tag that never comes ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= cycle_limit) begin
         $display("timeout after %0d cycles, %0d tags outstanding", cycle_count,
                  expected_tags.size());
         $display("gif_block_stream_parser regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus and end of test
   // ---------------------------------------------------------------------------------------
   initial begin
      string       signature;
      int          pick;
      logic [7:0]  b;
      logic [7:0]  packed_byte;
      logic        drain_planned;
      signature = "GIF89a";
      drain_planned = 1'b0;

      // Directed opening: header, screen descriptor with the smallest global table and
      // all reserved packed bits set, extreme data bytes, a control extension and a
      // plain image without a local table.
      foreach (signature[i]) put(signature[i]);
      put(8'hFF); put(8'h00); put(8'h01); put(8'h00);
      put(8'hF8);
      put(8'h00); put(8'hFF);
      put(8'h00); put(8'hFF); put(8'h55); put(8'hAA); put(8'h0F); put(8'hF0);
      largest_table = 6;
      put_gfx_ext();
      put_image(8'h40);

      // Random body: well-formed blocks with random content. One byte near the middle
      // waits for the parser to drain completely.
      while (gif_stream.size() < 1200) begin
         if (gif_stream.size() >= 600 && image_count + extension_count > 0 &&
             !drain_planned && $urandom_range(0, 3) == 0 && gif_stream.size() < 700) begin
            drain_request = 1'b1;
            drain_planned = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick < 6) begin
            put_gfx_ext();
         end else if (pick < 9) begin
            put(BYTE_EXT);
            put(LABEL_APP);
            repeat (12) put(8'($urandom));
            put_sub_chain();
            extension_count++;
         end else begin
            packed_byte = 8'($urandom);
            packed_byte[2:0] = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 2));
            put_image(packed_byte);
         end
      end
      // make sure the hold-off happened even if the random pick missed it
      if (!drain_planned) begin
         drain_request = 1'b1;
         drain_planned = 1'b1;
         put_gfx_ext();
      end

      // End the stream one of several ways; later bytes are noise the parser must ignore.
      case ($urandom_range(0, 4))
         0: begin
            put(BYTE_TRAILER);
            ending = "trailer";
         end
         1: begin
            do b = 8'($urandom);
            while (b == BYTE_EXT || b == BYTE_IMAGE || b == BYTE_TRAILER);
            put(b);
            ending = "unknown introducer";
         end
         2: begin
            put(BYTE_EXT);
            put(8'h01);
            ending = "plain text label";
         end
         3: begin
            put(BYTE_EXT);
            put(8'hFE);
            ending = "comment label";
         end
         default: begin
            put(BYTE_EXT);
            do b = 8'($urandom);
            while (b == LABEL_GFX || b == LABEL_APP);
            put(b);
            ending = "unknown label";
         end
      endcase
      repeat (24) put(8'($urandom));

      // several times the slowest legal run: every byte behind a full sender gap and a
      // full receiver stall
      cycle_limit = 100 * gif_stream.size() + 5000;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent, every tag back, then a pause for strays
      while (gif_stream.size() != 0 || req_valid) @(posedge clock);
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("streamed %0d bytes: %0d images, %0d extensions, largest color table %0d bytes",
               checked_count, image_count, extension_count, largest_table);
      $display("stream closed by %s, %0d failures", ending, error_count);
      if (error_count == 0) begin
         $display("gif_block_stream_parser regression: pass");
      end else begin
         $display("gif_block_stream_parser regression: fail");
      end
      $finish;
   end

endmodule
